// ----- design/event_frame_accumulator_core_defines.svh -----
// assertion macros for the event frame accumulator
`ifndef EVENT_FRAME_ACCUMULATOR_CORE_DEFINES_SVH
`define EVENT_FRAME_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication
`define EFA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("efa check failed");

// next-cycle implication
`define EFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("efa check failed");

`endif

// ----- design/efa_pkg.sv -----
// shared types and constants of the event frame accumulator
package efa_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_TIME      = 3'd6;

    localparam logic [1:0] REQ_EVENT = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_FRAME = 2'd2;

    localparam logic [1:0] POL_POSITIVE = 2'd0;
    localparam logic [1:0] POL_NEGATIVE = 2'd1;
    localparam logic [1:0] POL_BOTH     = 2'd2;

    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  ev_x;
        logic [9:0]  ev_y;
        logic [31:0] ev_time;
        logic        ev_polarity;
        logic [19:0] pixel_index;
        logic        clear_after_read;
    } in_req_t;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        event_used;
        logic        out_of_range;
        logic [31:0] events_used_count;
    } out_res_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic calc;
        logic read;
        logic update;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

// ----- design/efa_ram.sv -----
// generic single-port-write ram with registered read
module efa_ram #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned DEPTH      = 1024
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [DATA_WIDTH-1:0]         wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [DATA_WIDTH-1:0]         rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/efa_ctrl.sv -----
// controller state machine of the event frame accumulator
module efa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output efa_pkg::cmd_t    cmd,
    input  efa_pkg::status_t status
);

    import efa_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_CALC   = 6'b000100,
        ST_READ   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_PUSH   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:   state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_PUSH;
            ST_PUSH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.clear  = (state_reg == ST_CLEAR);
    assign cmd.load   = (state_reg == ST_IDLE) && s_valid;
    assign cmd.calc   = (state_reg == ST_CALC);
    assign cmd.read   = (state_reg == ST_READ);
    assign cmd.update = (state_reg == ST_UPDATE);
    assign cmd.push   = (state_reg == ST_PUSH);

endmodule

// ----- design/efa_datapath.sv -----
// datapath: config registers, filters, pixel store, counters and result register
module efa_datapath #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [efa_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [efa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  efa_pkg::in_req_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output efa_pkg::out_res_t                   m_data,
    input  efa_pkg::cmd_t                       cmd,
    output efa_pkg::status_t                    status
);

    import efa_pkg::*;

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);

    // configuration
    logic [10:0] cfg_width_reg;
    logic [10:0] cfg_height_reg;
    logic [1:0]  cfg_pol_reg;
    logic        cfg_sum_reg;
    logic [31:0] cfg_start_reg;
    logic [31:0] cfg_len_reg;
    logic [30:0] cfg_ref_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= RST_IMAGE_WIDTH;
            cfg_height_reg <= RST_IMAGE_HEIGHT;
            cfg_pol_reg    <= POL_POSITIVE;
            cfg_sum_reg    <= 1'b0;
            cfg_start_reg  <= '0;
            cfg_len_reg    <= '0;
            cfg_ref_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_IMAGE_WIDTH:   cfg_width_reg  <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT:  cfg_height_reg <= cfg_data[10:0];
                CFG_POLARITY_MODE: cfg_pol_reg    <= cfg_data[1:0];
                CFG_SUM_MODE:      cfg_sum_reg    <= cfg_data[0];
                CFG_WINDOW_START:  cfg_start_reg  <= cfg_data;
                CFG_WINDOW_LENGTH: cfg_len_reg    <= cfg_data;
                CFG_REF_TIME:      cfg_ref_reg    <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // request capture
    in_req_t req_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_data;
        end
    end

    // address and filter stage
    logic [10:0] eff_w;
    logic [10:0] eff_h;
    logic [21:0] ev_addr;
    logic [21:0] area;
    logic [32:0] hi_sum;
    logic [31:0] win_hi;
    logic        win_ok;
    logic        pol_ok;
    logic        oor_next;
    logic [AW-1:0] addr_next;

    assign eff_w = (32'(cfg_width_reg) > 32'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : cfg_width_reg;
    assign eff_h = (32'(cfg_height_reg) > 32'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : cfg_height_reg;
    assign ev_addr = 22'(req_reg.ev_y) * 22'(eff_w) + 22'(req_reg.ev_x);
    assign area    = 22'(eff_w) * 22'(eff_h);
    assign hi_sum  = {1'b0, cfg_start_reg} + {1'b0, cfg_len_reg};
    assign win_hi  = hi_sum[32] ? ALL_ONES : hi_sum[31:0];
    assign win_ok  = (req_reg.ev_time >= cfg_start_reg)
                   && ((cfg_len_reg == '0) || (req_reg.ev_time <= win_hi));

    always_comb begin
        case (cfg_pol_reg)
            POL_BOTH:     pol_ok = 1'b1;
            POL_NEGATIVE: pol_ok = !req_reg.ev_polarity;
            default:      pol_ok = req_reg.ev_polarity;
        endcase
    end

    always_comb begin
        oor_next  = 1'b0;
        addr_next = AW'(ev_addr);
        case (req_reg.req_type)
            REQ_EVENT: begin
                oor_next = (11'(req_reg.ev_x) >= eff_w) || (11'(req_reg.ev_y) >= eff_h);
            end
            REQ_READ: begin
                oor_next  = ({2'b00, req_reg.pixel_index} >= area);
                addr_next = AW'(req_reg.pixel_index);
            end
            default: oor_next = 1'b0;
        endcase
    end

    logic [AW-1:0] addr_reg;
    logic          oor_reg;
    logic          pass_reg;

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            addr_reg <= addr_next;
            oor_reg  <= oor_next;
            pass_reg <= win_ok && pol_ok;
        end
    end

    // pixel store and its clearing pass
    logic [AW-1:0] clr_cnt_reg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign status.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));

    efa_ram #(
        .DATA_WIDTH (32),
        .DEPTH      (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // read-modify-write and result
    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic        upd_we;
    logic [31:0] upd_wdata;
    out_res_t    res_calc;

    always_comb begin
        upd_we     = 1'b0;
        upd_wdata  = '0;
        count_next = count_reg;
        res_calc   = '0;
        case (req_reg.req_type)
            REQ_EVENT: begin
                res_calc.out_of_range = oor_reg;
                if (!oor_reg && pass_reg) begin
                    upd_we = 1'b1;
                    if (cfg_sum_reg) begin
                        upd_wdata = (ram_rdata == ALL_ONES) ? ram_rdata : ram_rdata + 32'd1;
                    end else begin
                        upd_wdata = req_reg.ev_time;
                    end
                    count_next = (count_reg == ALL_ONES) ? count_reg : count_reg + 32'd1;
                    res_calc.event_used = 1'b1;
                end
            end
            REQ_READ: begin
                res_calc.out_of_range = oor_reg;
                if (!oor_reg) begin
                    if ((ram_rdata == '0) && (cfg_ref_reg != '0)) begin
                        res_calc.pixel_value = {1'b0, cfg_ref_reg};
                    end else begin
                        res_calc.pixel_value = ram_rdata;
                    end
                    upd_we = req_reg.clear_after_read;
                end
            end
            REQ_FRAME: count_next = '0;
            default: ;
        endcase
        res_calc.events_used_count = count_next;
    end

    assign ram_we    = cmd.clear || (cmd.update && upd_we);
    assign ram_waddr = cmd.clear ? clr_cnt_reg : addr_reg;
    assign ram_wdata = cmd.clear ? 32'd0 : upd_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.update) begin
            count_reg <= count_next;
        end
    end

    out_res_t res_reg;

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            res_reg <= res_calc;
        end
    end

    // output register
    logic     m_valid_reg;
    out_res_t m_data_reg;

    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push && status.out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && status.out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- design/event_frame_accumulator_core.sv -----
// event frame accumulator top level
// a request passes through the calc, read, update and push states; push waits until the output is free
// a new request is accepted only after the pixel store read-modify-write and push of the last one are done
// reset: synchronous active-low; clears control state, events count and config registers
// after reset a clearing pass zeroes every word of the pixel store (MAX_WIDTH * MAX_HEIGHT words),
// during which s_ready stays low; config writes are taken throughout
`include "event_frame_accumulator_core_defines.svh"

module event_frame_accumulator_core #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [efa_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [efa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  efa_pkg::in_req_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output efa_pkg::out_res_t               m_data
);

    import efa_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    efa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    efa_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

    // no request taken while the store is being cleared
    `EFA_ASSERT_NOW(a_no_accept_in_clear, aclk, aresetn, cmd.clear, !s_ready)
    // one request in flight at a time
    `EFA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // every store read is followed by its update
    `EFA_ASSERT_NEXT(a_read_then_update, aclk, aresetn, cmd.read, cmd.update)
    // a result is produced after every update
    `EFA_ASSERT_NEXT(a_update_then_push, aclk, aresetn, cmd.update, cmd.push)

endmodule

// ----- bench/event_frame_accumulator_core_tb.sv -----
// self-checking testbench for the event frame accumulator core
`timescale 1ns / 1ps

module event_frame_accumulator_core_tb;
    import efa_pkg::*;

    localparam int unsigned FRAME_COLS  = 1024;
    localparam int unsigned FRAME_ROWS  = 1024;
    localparam int unsigned STALL_LIMIT = 4 * FRAME_COLS * FRAME_ROWS + 20000;
    localparam logic [1:0]  REQ_NONE    = 2'd3;

    class frame_scoreboard;
        bit [10:0]  width_reg;
        bit [10:0]  height_reg;
        bit [1:0]   pol_reg;
        bit         sum_on;
        bit [31:0]  win_start;
        bit [31:0]  win_len;
        bit [30:0]  ref_time_reg;
        bit [31:0]  pixels [int unsigned];
        bit [31:0]  used_total;
        out_res_t   expected_q [$];
        int unsigned failures;

        function new();
            width_reg    = RST_IMAGE_WIDTH;
            height_reg   = RST_IMAGE_HEIGHT;
            pol_reg      = POL_POSITIVE;
            sum_on       = 1'b0;
            win_start    = '0;
            win_len      = '0;
            ref_time_reg = '0;
            used_total   = '0;
            failures     = 0;
        endfunction

        function int unsigned cols();
            return width_reg > FRAME_COLS ? FRAME_COLS : width_reg;
        endfunction

        function int unsigned rows();
            return height_reg > FRAME_ROWS ? FRAME_ROWS : height_reg;
        endfunction

        function bit [31:0] window_end();
            bit [32:0] total;
            total = win_start + win_len;
            if (win_len == 0 || total[32]) begin
                return ALL_ONES;
            end
            return total[31:0];
        endfunction

        function bit [31:0] bump(bit [31:0] v);
            return v == ALL_ONES ? v : v + 1;
        endfunction

        function bit [31:0] read_pixel(int unsigned a);
            return pixels.exists(a) ? pixels[a] : 32'd0;
        endfunction

        function bit polarity_match(bit p);
            case (pol_reg)
                POL_BOTH: begin
                    return 1'b1;
                end
                POL_NEGATIVE: begin
                    return p == 1'b0;
                end
                default: begin
                    return p == 1'b1;
                end
            endcase
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:   width_reg    = data[10:0];
                CFG_IMAGE_HEIGHT:  height_reg   = data[10:0];
                CFG_POLARITY_MODE: pol_reg      = data[1:0];
                CFG_SUM_MODE:      sum_on       = data[0];
                CFG_WINDOW_START:  win_start    = data;
                CFG_WINDOW_LENGTH: win_len      = data;
                CFG_REF_TIME:      ref_time_reg = data[30:0];
                default: ;
            endcase
        endfunction

        function void note_request(in_req_t r);
            out_res_t    e;
            int unsigned w;
            int unsigned h;
            int unsigned a;
            bit [31:0]   v;
            e = '0;
            w = cols();
            h = rows();
            case (r.req_type)
                REQ_EVENT: begin
                    if (r.ev_x >= w || r.ev_y >= h) begin
                        e.out_of_range = 1'b1;
                    end else if (r.ev_time >= win_start && r.ev_time <= window_end()
                                 && polarity_match(r.ev_polarity)) begin
                        a = r.ev_y * w + r.ev_x;
                        pixels[a] = sum_on ? bump(read_pixel(a)) : r.ev_time;
                        used_total = bump(used_total);
                        e.event_used = 1'b1;
                    end
                end
                REQ_READ: begin
                    if (r.pixel_index >= w * h) begin
                        e.out_of_range = 1'b1;
                    end else begin
                        v = read_pixel(r.pixel_index);
                        e.pixel_value = (v == 0 && ref_time_reg != 0) ? {1'b0, ref_time_reg} : v;
                        if (r.clear_after_read) begin
                            pixels.delete(r.pixel_index);
                        end
                    end
                end
                REQ_FRAME: begin
                    used_total = '0;
                end
                default: ;
            endcase
            e.events_used_count = used_total;
            expected_q.push_back(e);
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
            failures++;
            if (failures <= 10) begin
                $display("mismatch %s: expected %0h, got %0h", what, exp_v, got_v);
            end
        endfunction

        function void check_result(out_res_t got);
            out_res_t e;
            if (expected_q.size() == 0) begin
                report("result with no request outstanding", '0, got.events_used_count);
                return;
            end
            e = expected_q.pop_front();
            if (got.pixel_value !== e.pixel_value)
                report("pixel_value", e.pixel_value, got.pixel_value);
            if (got.event_used !== e.event_used)
                report("event_used", e.event_used, got.event_used);
            if (got.out_of_range !== e.out_of_range)
                report("out_of_range", e.out_of_range, got.out_of_range);
            if (got.events_used_count !== e.events_used_count)
                report("events_used_count", e.events_used_count, got.events_used_count);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0) begin
                report("results never returned", '0, expected_q.size());
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    in_req_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_res_t              m_data;

    frame_scoreboard sb = new();

    bit          quiet = 1'b0;
    bit          s_hit = 1'b0;
    bit          res_hit = 1'b0;
    bit          cfg_hit = 1'b0;
    out_res_t    res_seen;
    int unsigned idle_cycles = 0;
    int unsigned recent_pix [$];

    event_frame_accumulator_core #(
        .MAX_WIDTH  (FRAME_COLS),
        .MAX_HEIGHT (FRAME_ROWS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // handshakes are sampled mid-cycle and acted on at the next rising edge
    always @(negedge aclk) begin
        s_hit    = s_valid && s_ready;
        res_hit  = m_valid && m_ready;
        cfg_hit  = cfg_valid && cfg_ready;
        res_seen = m_data;
    end

    always @(posedge aclk) begin
        if (res_hit) begin
            sb.check_result(res_seen);
        end
        if (s_hit || res_hit || cfg_hit) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            if (quiet) begin
                @(posedge aclk);
            end else begin
                repeat ($urandom_range(9, 0) == 0 ? $urandom_range(120, 40)
                                                  : $urandom_range(8, 1)) @(posedge aclk);
                stall = pick_gap();
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    function automatic in_req_t noise_req();
        in_req_t r;
        r.req_type         = $urandom;
        r.ev_x             = $urandom;
        r.ev_y             = $urandom;
        r.ev_time          = $urandom;
        r.ev_polarity      = $urandom;
        r.pixel_index      = $urandom;
        r.clear_after_read = $urandom;
        return r;
    endfunction

    function automatic in_req_t event_req(logic [9:0] x, logic [9:0] y, logic [31:0] t,
                                          logic p);
        in_req_t r;
        r             = noise_req();
        r.req_type    = REQ_EVENT;
        r.ev_x        = x;
        r.ev_y        = y;
        r.ev_time     = t;
        r.ev_polarity = p;
        return r;
    endfunction

    function automatic in_req_t read_req(logic [19:0] idx, logic clr);
        in_req_t r;
        r                  = noise_req();
        r.req_type         = REQ_READ;
        r.pixel_index      = idx;
        r.clear_after_read = clr;
        return r;
    endfunction

    function automatic in_req_t plain_req(logic [1:0] kind);
        in_req_t r;
        r          = noise_req();
        r.req_type = kind;
        return r;
    endfunction

    function automatic in_req_t pick_request();
        in_req_t     r;
        int unsigned w;
        int unsigned h;
        int unsigned roll;
        bit [31:0]   hi;
        bit [31:0]   t;
        bit          p;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [19:0] idx;
        w    = sb.cols();
        h    = sb.rows();
        hi   = sb.window_end();
        roll = $urandom_range(99, 0);
        if (roll < 55) begin
            x = (w > 0 && $urandom_range(9, 0) != 0) ? $urandom_range(w - 1, 0) : $urandom;
            y = (h > 0 && $urandom_range(9, 0) != 0) ? $urandom_range(h - 1, 0) : $urandom;
            case ($urandom_range(9, 0))
                0: t = sb.win_start;
                1: t = hi;
                2: t = sb.win_start - 1;
                3: t = hi + 1;
                4: t = $urandom;
                default: t = $urandom_range(hi, sb.win_start);
            endcase
            if ($urandom_range(4, 0) == 0) begin
                p = $urandom;
            end else begin
                case (sb.pol_reg)
                    POL_BOTH:     p = $urandom;
                    POL_NEGATIVE: p = 1'b0;
                    default:      p = 1'b1;
                endcase
            end
            if (x < w && y < h) begin
                recent_pix.push_back(y * w + x);
                if (recent_pix.size() > 16) begin
                    void'(recent_pix.pop_front());
                end
            end
            r = event_req(x, y, t, p);
        end else if (roll < 85) begin
            roll = $urandom_range(99, 0);
            if (roll < 50 && recent_pix.size() != 0) begin
                idx = recent_pix[$urandom_range(recent_pix.size() - 1, 0)];
            end else if (roll < 85 && w * h != 0) begin
                idx = $urandom_range(w * h - 1, 0);
            end else begin
                idx = $urandom;
            end
            r = read_req(idx, $urandom_range(9, 0) < 3);
        end else if (roll < 93) begin
            r = plain_req(REQ_FRAME);
        end else if (roll < 96) begin
            r = plain_req(REQ_NONE);
        end else begin
            r = noise_req();
        end
        return r;
    endfunction

    task automatic send(input in_req_t r);
        s_data  <= r;
        s_valid <= 1'b1;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        sb.note_request(r);
    endtask

    task automatic issue(input in_req_t r);
        int unsigned gap;
        send(r);
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned width,
                             input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] word;
        mask = (width >= 32) ? ALL_ONES : (32'd1 << width) - 1;
        word = ($urandom & ~mask) | (value & mask);
        cfg_addr  <= idx;
        cfg_data  <= word;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        sb.set_reg(idx, word);
    endtask

    task automatic apply_setup(input int unsigned w, input int unsigned h,
                               input logic [1:0] pol, input logic sum_mode,
                               input logic [31:0] ws, input logic [31:0] wl,
                               input logic [30:0] rt);
        s_valid <= 1'b0;
        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, 11, w);
        cfg_write(CFG_IMAGE_HEIGHT, 11, h);
        cfg_write(CFG_POLARITY_MODE, 2, pol);
        cfg_write(CFG_SUM_MODE, 1, sum_mode);
        cfg_write(CFG_WINDOW_START, 32, ws);
        cfg_write(CFG_WINDOW_LENGTH, 32, wl);
        cfg_write(CFG_REF_TIME, 31, rt);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count, input bit calm);
        quiet = calm;
        repeat (count) issue(pick_request());
        quiet = 1'b0;
    endtask

    function automatic int unsigned pick_size();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 70) return $urandom_range(12, 1);
        if (roll < 85) return $urandom_range(2047, 1025);
        return $urandom_range(1024, 0);
    endfunction

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("event_frame_accumulator_core_tb failed");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: 640 x 480, positive only, timestamp mode
        issue(event_req(10'd639, 10'd479, ALL_ONES, 1'b1));
        issue(event_req(10'd640, 10'd0, 32'd5, 1'b1));
        issue(event_req(10'd0, 10'd480, 32'd5, 1'b1));
        issue(event_req(10'd1023, 10'd1023, 32'd5, 1'b1));
        issue(event_req(10'd0, 10'd0, 32'd0, 1'b1));
        issue(event_req(10'd3, 10'd2, 32'd77, 1'b0));
        issue(read_req(20'd307199, 1'b0));
        issue(read_req(20'd307199, 1'b1));
        issue(read_req(20'd307199, 1'b0));
        issue(read_req(20'd0, 1'b0));
        issue(read_req(20'd307200, 1'b0));
        issue(read_req(20'hFFFFF, 1'b1));
        issue(plain_req(REQ_FRAME));
        issue(plain_req(REQ_NONE));

        // timestamps near the top on a 4 x 4 frame, then per-pixel event counting in sum mode
        apply_setup(4, 4, POL_BOTH, 1'b0, 32'd0, 32'd0, 31'd0);
        issue(event_req(10'd1, 10'd1, ALL_ONES, 1'b0));
        issue(event_req(10'd2, 10'd1, 32'hFFFF_FFFE, 1'b1));
        apply_setup(4, 4, POL_BOTH, 1'b1, 32'd0, 32'd0, 31'd0);
        issue(event_req(10'd1, 10'd1, 32'd9, 1'b1));
        issue(event_req(10'd2, 10'd1, 32'd9, 1'b0));
        issue(event_req(10'd2, 10'd1, 32'd9, 1'b1));
        issue(read_req(20'd5, 1'b1));
        issue(read_req(20'd6, 1'b1));

        run_random(110, 1'b0);
        apply_setup(4, 4, POL_POSITIVE, 1'b0, 32'd0, 32'd0, 31'h7FFF_FFFF);
        run_random(110, 1'b1);
        apply_setup(8, 3, POL_NEGATIVE, 1'b1, 32'd1000, 32'd50, 31'd5);
        run_random(110, 1'b0);
        apply_setup(2047, 2047, POL_BOTH, 1'b0, 32'd0, 32'd0, 31'd0);
        run_random(110, 1'b0);
        apply_setup(1024, 1024, 2'd3, 1'b1, 32'd0, 32'd0, 31'd1);
        run_random(110, 1'b0);
        apply_setup(0, 5, POL_BOTH, 1'b0, 32'd0, 32'd0, 31'd3);
        run_random(110, 1'b0);
        apply_setup(5, 0, POL_BOTH, 1'b1, 32'd0, 32'd0, 31'd3);
        run_random(110, 1'b1);
        apply_setup(1, 1, POL_BOTH, 1'b1, 32'hF000_0000, ALL_ONES, 31'd1);
        run_random(110, 1'b0);
        apply_setup(3, 7, POL_POSITIVE, 1'b0, ALL_ONES, 32'd0, 31'h55);
        run_random(110, 1'b0);
        apply_setup(1024, 1, POL_BOTH, 1'b0, 32'd0, ALL_ONES, 31'h1234);
        run_random(110, 1'b0);
        apply_setup(1, 1024, POL_NEGATIVE, 1'b1, 32'd0, 32'd0, 31'd0);
        run_random(110, 1'b0);
        repeat (4) begin
            apply_setup(pick_size(), pick_size(), $urandom_range(3, 0), $urandom,
                        $urandom_range(1, 0) ? 32'd0 : $urandom,
                        $urandom_range(2, 0) == 0 ? 32'd0 : $urandom,
                        $urandom_range(1, 0) ? 31'd0 : 31'($urandom));
            run_random(110, 1'b0);
        end

        s_valid <= 1'b0;
        wait_idle();
        repeat (16) @(posedge aclk);
        sb.close_out();
        if (sb.failures == 0) begin
            $display("event_frame_accumulator_core_tb passed");
        end else begin
            $display("event_frame_accumulator_core_tb failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/efa_pkg.sv
design/efa_ram.sv
design/efa_ctrl.sv
design/efa_datapath.sv
design/event_frame_accumulator_core.sv
bench/event_frame_accumulator_core_tb.sv
